// ===== design/lorenz_euler_trail_engine_macros.svh =====
// Assertion macros for the Lorenz trail engine.
// No dependencies; included by the top level.
`ifndef LORENZ_EULER_TRAIL_ENGINE_MACROS_SVH
`define LORENZ_EULER_TRAIL_ENGINE_MACROS_SVH

// same-cycle implication under active-low reset
`define LORENZ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lorenz assertion failed");

// next-cycle implication under active-low reset
`define LORENZ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lorenz assertion failed");

`endif

// ===== design/lorenz_pkg.sv =====
// Shared types, constants and helpers for the Lorenz trail engine.
// No dependencies; imported by every module of the block.
`default_nettype none

package lorenz_pkg;

  localparam int unsigned NUM_POINTS = 16384;
  localparam int unsigned TAIL_LEN   = 2;

  localparam int unsigned PT_W   = 14;
  localparam int unsigned POS_W  = 32;
  localparam int unsigned DT_W   = 31;
  localparam int unsigned TPOS_W = 4;
  localparam int unsigned IDX_W  = 2;

  localparam int unsigned SLOT_W = (TAIL_LEN > 1) ? $clog2(TAIL_LEN) : 1;
  localparam int unsigned DEPTH  = NUM_POINTS * TAIL_LEN;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_STEP = 1'b1
  } func_e;

  typedef enum logic [IDX_W-1:0] {
    REG_SIGMA = 2'd0,
    REG_RHO   = 2'd1,
    REG_BETA  = 2'd2,
    REG_DT    = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    OP_SIG_DIFF = 3'd0,
    OP_DX       = 3'd1,
    OP_X_RHOZ   = 3'd2,
    OP_DY       = 3'd3,
    OP_XY       = 3'd4,
    OP_BETAZ    = 3'd5,
    OP_DZ       = 3'd6
  } mul_op_e;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_LOAD,
    BK_HEAD_RD,
    BK_HEAD_LAT,
    BK_OPND,
    BK_MUL,
    BK_STORE,
    BK_UPDATE,
    BK_SHIFT_RD,
    BK_SHIFT_WR,
    BK_HEAD_WR
  } back_state_e;

  typedef struct packed {
    func_e             func;
    logic [PT_W-1:0]   point_index;
    logic [POS_W-1:0]  load_x;
    logic [POS_W-1:0]  load_y;
    logic [POS_W-1:0]  load_z;
  } item_t;

  typedef struct packed {
    logic [PT_W-1:0]   out_point;
    logic [TPOS_W-1:0] trail_pos;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [POS_W-1:0]  pos_z;
    logic              last_entry;
  } out_item_t;

  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [POS_W-1:0] z;
  } pos_t;

  typedef struct packed {
    func_e           func;
    logic [PT_W-1:0] point;
    pos_t            pos;
  } cmd_t;

  typedef struct packed {
    logic [POS_W-1:0] sigma;
    logic [POS_W-1:0] rho;
    logic [POS_W-1:0] beta;
    logic [DT_W-1:0]  dt;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    sigma: 32'h0A00_0000,
    rho:   32'h1C00_0000,
    beta:  32'h02AA_AAAB,
    dt:    31'd83886
  };

  // clamp a 33-bit two's complement value to 32 bits
  function automatic logic [POS_W-1:0] sat33(input logic [POS_W:0] v);
    logic [POS_W-1:0] r;
    if (v[POS_W] != v[POS_W-1]) begin
      r = v[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/lorenz_qmul.sv =====
// Q8.24 multiplier: registered product, then round-half-up and saturate.
// Depends on lorenz_pkg.
`default_nettype none

module lorenz_qmul (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [lorenz_pkg::POS_W-1:0] a_i,
  input  logic [lorenz_pkg::POS_W-1:0] b_i,
  output logic [lorenz_pkg::POS_W-1:0] res_o
);
  import lorenz_pkg::*;

  localparam int unsigned PROD_W = 2 * POS_W;
  localparam int unsigned FRAC_W = 24;

  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] rnd;
  logic                     in_range;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= $signed(a_i) * $signed(b_i);
    end
  end

  assign rnd = prod_q + (PROD_W'(1) <<< (FRAC_W - 1));
  assign in_range = (&rnd[PROD_W-1:FRAC_W+POS_W-1]) | ~(|rnd[PROD_W-1:FRAC_W+POS_W-1]);

  always_comb begin
    if (in_range) begin
      res_o = rnd[FRAC_W+POS_W-1:FRAC_W];
    end else if (rnd[PROD_W-1]) begin
      res_o = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      res_o = {1'b0, {(POS_W-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

// ===== design/lorenz_front.sv =====
// Front end: takes items, drops out-of-range points, queues commands.
// Depends on lorenz_pkg.
`default_nettype none

module lorenz_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  lorenz_pkg::item_t  item_i,
  output logic               busy_o,
  output logic               cmd_valid_o,
  output lorenz_pkg::cmd_t   cmd_o,
  input  logic               cmd_ready_i
);
  import lorenz_pkg::*;

  cmd_t              queue_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              accept;
  logic              in_range;
  logic              push;
  logic              pop;
  cmd_t              new_cmd;

  assign busy_o      = (32'(cnt_q) == QDEPTH);
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];

  assign accept   = start_i && !busy_o;
  assign in_range = (32'(item_i.point_index) < NUM_POINTS);
  assign push     = accept && in_range;
  assign pop      = cmd_valid_o && cmd_ready_i;

  assign new_cmd.func  = item_i.func;
  assign new_cmd.point = item_i.point_index;
  assign new_cmd.pos.x = item_i.load_x;
  assign new_cmd.pos.y = item_i.load_y;
  assign new_cmd.pos.z = item_i.load_z;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (32'(wr_ptr_q) == QDEPTH - 1) ? '0 : QPTR_W'(wr_ptr_q + 1'b1);
    end
    if (pop) begin
      rd_ptr_d = (32'(rd_ptr_q) == QDEPTH - 1) ? '0 : QPTR_W'(rd_ptr_q + 1'b1);
    end
    if (push && !pop) begin
      cnt_d = QCNT_W'(cnt_q + 1'b1);
    end else if (pop && !push) begin
      cnt_d = QCNT_W'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= new_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== design/lorenz_back.sv =====
// Back end: trail memory, Euler step sequencer and result emission.
// Depends on lorenz_pkg and lorenz_qmul.
`default_nettype none

module lorenz_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  input  lorenz_pkg::cmd_t      cmd_i,
  output logic                  cmd_ready_o,
  input  lorenz_pkg::cfg_t      cfg_i,
  output logic                  result_valid_o,
  output lorenz_pkg::out_item_t result_o
);
  import lorenz_pkg::*;

  localparam int unsigned SLOT_LAST  = TAIL_LEN - 1;
  localparam int unsigned SHIFT_LAST = (TAIL_LEN > 1) ? TAIL_LEN - 2 : 0;

  back_state_e       state_q, state_d;
  cmd_t              cmd_q;
  logic [SLOT_W-1:0] slot_q;
  logic [SLOT_W-1:0] slot_next;
  mul_op_e           op_q;

  logic [POS_W-1:0]  x_q, y_q, z_q;
  logic [POS_W-1:0]  t_q, u_q;
  logic [POS_W-1:0]  dx_q, dy_q, dz_q;
  logic [POS_W-1:0]  opa_q, opb_q, opa_d, opb_d;
  logic [POS_W-1:0]  mul_res;
  logic [POS_W-1:0]  dt_ext;
  pos_t              new_q;

  pos_t              trail_mem_q [DEPTH];
  pos_t              rd_q;
  logic              mem_we;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  pos_t              wr_data;

  logic              emit;
  logic              emit_last;
  pos_t              emit_pos;
  logic              mul_en;

  logic              out_vld_q;
  out_item_t         out_q;

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [PT_W-1:0] pt,
                                                  input logic [SLOT_W-1:0] s);
    logic [31:0] full;
    full = 32'(pt) * TAIL_LEN + 32'(s);
    return full[ADDR_W-1:0];
  endfunction

  assign slot_next = SLOT_W'(slot_q + 1'b1);
  assign dt_ext    = POS_W'({1'b0, cfg_i.dt});

  lorenz_qmul u_qmul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (opa_q),
    .b_i   (opb_q),
    .res_o (mul_res)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          state_d = (cmd_i.func == FUNC_STEP) ? BK_HEAD_RD : BK_LOAD;
        end
      end
      BK_LOAD: begin
        if (32'(slot_q) == SLOT_LAST) begin
          state_d = BK_IDLE;
        end
      end
      BK_HEAD_RD:  state_d = BK_HEAD_LAT;
      BK_HEAD_LAT: state_d = BK_OPND;
      BK_OPND:     state_d = BK_MUL;
      BK_MUL:      state_d = BK_STORE;
      BK_STORE: begin
        state_d = (op_q == OP_DZ) ? BK_UPDATE : BK_OPND;
      end
      BK_UPDATE: begin
        state_d = (TAIL_LEN > 1) ? BK_SHIFT_RD : BK_HEAD_WR;
      end
      BK_SHIFT_RD: state_d = BK_SHIFT_WR;
      BK_SHIFT_WR: begin
        state_d = (32'(slot_q) == SHIFT_LAST) ? BK_HEAD_WR : BK_SHIFT_RD;
      end
      BK_HEAD_WR:  state_d = BK_IDLE;
      default:     state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready_o = 1'b0;
    mem_we      = 1'b0;
    wr_addr     = slot_addr(cmd_q.point, slot_q);
    wr_data     = rd_q;
    rd_addr     = slot_addr(cmd_q.point, slot_next);
    emit        = 1'b0;
    emit_last   = 1'b0;
    emit_pos    = rd_q;
    mul_en      = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        cmd_ready_o = 1'b1;
      end
      BK_LOAD: begin
        mem_we  = 1'b1;
        wr_data = cmd_q.pos;
      end
      BK_HEAD_RD: begin
        rd_addr = slot_addr(cmd_q.point, SLOT_W'(SLOT_LAST));
      end
      BK_MUL: begin
        mul_en = 1'b1;
      end
      BK_SHIFT_WR: begin
        mem_we = 1'b1;
        emit   = 1'b1;
      end
      BK_HEAD_WR: begin
        mem_we    = 1'b1;
        wr_addr   = slot_addr(cmd_q.point, SLOT_W'(SLOT_LAST));
        wr_data   = new_q;
        emit      = 1'b1;
        emit_last = 1'b1;
        emit_pos  = new_q;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    unique case (op_q)
      OP_SIG_DIFF: begin
        opa_d = cfg_i.sigma;
        opb_d = sat33({y_q[POS_W-1], y_q} - {x_q[POS_W-1], x_q});
      end
      OP_DX: begin
        opa_d = t_q;
        opb_d = dt_ext;
      end
      OP_X_RHOZ: begin
        opa_d = x_q;
        opb_d = sat33({cfg_i.rho[POS_W-1], cfg_i.rho} - {z_q[POS_W-1], z_q});
      end
      OP_DY: begin
        opa_d = sat33({t_q[POS_W-1], t_q} - {y_q[POS_W-1], y_q});
        opb_d = dt_ext;
      end
      OP_XY: begin
        opa_d = x_q;
        opb_d = y_q;
      end
      OP_BETAZ: begin
        opa_d = cfg_i.beta;
        opb_d = z_q;
      end
      OP_DZ: begin
        opa_d = sat33({t_q[POS_W-1], t_q} - {u_q[POS_W-1], u_q});
        opb_d = dt_ext;
      end
      default: begin
        opa_d = x_q;
        opb_d = y_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == BK_IDLE && cmd_valid_i) begin
      cmd_q  <= cmd_i;
      slot_q <= '0;
    end
    if (state_q == BK_LOAD || state_q == BK_SHIFT_WR) begin
      slot_q <= slot_next;
    end
    if (state_q == BK_HEAD_LAT) begin
      x_q  <= rd_q.x;
      y_q  <= rd_q.y;
      z_q  <= rd_q.z;
      op_q <= OP_SIG_DIFF;
    end
    if (state_q == BK_OPND) begin
      opa_q <= opa_d;
      opb_q <= opb_d;
    end
    if (state_q == BK_STORE) begin
      unique case (op_q)
        OP_SIG_DIFF: t_q  <= mul_res;
        OP_DX:       dx_q <= mul_res;
        OP_X_RHOZ:   t_q  <= mul_res;
        OP_DY:       dy_q <= mul_res;
        OP_XY:       t_q  <= mul_res;
        OP_BETAZ:    u_q  <= mul_res;
        OP_DZ:       dz_q <= mul_res;
        default:     t_q  <= mul_res;
      endcase
      op_q <= mul_op_e'(3'(op_q + 3'd1));
    end
    if (state_q == BK_UPDATE) begin
      new_q.x <= sat33({x_q[POS_W-1], x_q} + {dx_q[POS_W-1], dx_q});
      new_q.y <= sat33({y_q[POS_W-1], y_q} + {dy_q[POS_W-1], dy_q});
      new_q.z <= sat33({z_q[POS_W-1], z_q} + {dz_q[POS_W-1], dz_q});
      slot_q  <= '0;
    end
    if (emit) begin
      out_q.out_point  <= cmd_q.point;
      out_q.trail_pos  <= emit_last ? TPOS_W'(SLOT_LAST) : TPOS_W'(slot_q);
      out_q.pos_x      <= emit_pos.x;
      out_q.pos_y      <= emit_pos.y;
      out_q.pos_z      <= emit_pos.z;
      out_q.last_entry <= emit_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      trail_mem_q[wr_addr] <= wr_data;
    end
    rd_q <= trail_mem_q[rd_addr];
  end

  assign result_valid_o = out_vld_q;
  assign result_o       = out_q;

endmodule

`default_nettype wire

// ===== design/lorenz_euler_trail_engine.sv =====
// Top level of the Lorenz trail engine: configuration registers, front and back.
// Depends on lorenz_pkg, lorenz_front, lorenz_back and the assertion macro header.
//
//   port group            direction  handshake
//   start / item_i        in         start & !busy
//   result_valid_o / result_o  out   strobe, one cycle, no backpressure
//   cfg_*                 in         cfg_valid_i & cfg_ready_o (always ready)
//
// A step reads the head, runs seven products through the one shared multiplier
// (operand, multiply, store each), then updates, shifts and writes the head.
// A load makes one trail write per cycle and emits nothing.
// Reset loads the default coefficients and empties the command queue; the trail
// memory is not cleared. busy rises while the two-entry command queue is full.
`default_nettype none

`include "lorenz_euler_trail_engine_macros.svh"

module lorenz_euler_trail_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  input  lorenz_pkg::item_t             item_i,
  output logic                          busy,
  output logic                          result_valid_o,
  output lorenz_pkg::out_item_t         result_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lorenz_pkg::IDX_W-1:0]  cfg_index_i,
  input  logic [lorenz_pkg::POS_W-1:0]  cfg_data_i
);
  import lorenz_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_SIGMA: cfg_d.sigma = cfg_data_i;
        REG_RHO:   cfg_d.rho   = cfg_data_i;
        REG_BETA:  cfg_d.beta  = cfg_data_i;
        REG_DT:    cfg_d.dt    = cfg_data_i[DT_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  lorenz_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .item_i      (item_i),
    .busy_o      (busy),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  lorenz_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd),
    .cmd_ready_o    (cmd_ready),
    .cfg_i          (cfg_q),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  `LORENZ_ASSERT_IMPL(a_last_slot, clk_i, rst_ni, result_valid_o && result_o.last_entry, result_o.trail_pos == TPOS_W'(TAIL_LEN - 1))
  `LORENZ_ASSERT_NEXT(a_last_gap, clk_i, rst_ni, result_valid_o && result_o.last_entry, !result_valid_o)
  `LORENZ_ASSERT_NEXT(a_cfg_sigma, clk_i, rst_ni, cfg_valid_i && cfg_ready_o && cfg_index_i == REG_SIGMA, cfg_q.sigma == $past(cfg_data_i))

endmodule

`default_nettype wire
